[hdl/qpr_pkg.sv]
// Shared constants, register codes and pipeline control types of the quaternion point rotator.
package qpr_pkg;

    // Default sizes of the coordinate and quaternion fields.
    localparam int COORD_BITS_DEF     = 24;
    localparam int QUAT_FRAC_BITS_DEF = 15;

    // Configuration register file.
    localparam int NUM_REGS     = 4;
    localparam int CFG_IDX_BITS = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ROT_X = 2'd0,
        REG_ROT_Y = 2'd1,
        REG_ROT_Z = 2'd2,
        REG_ROT_W = 2'd3
    } t_reg_idx;

    // Component positions inside a quaternion array (x, y, z, w).
    localparam int IX = 0;
    localparam int IY = 1;
    localparam int IZ = 2;
    localparam int IW = 3;

    // Pipeline stages, in order from input to output.
    localparam int ST_QP_MUL   = 0;
    localparam int ST_QP_SUM   = 1;
    localparam int ST_TC_MUL   = 2;
    localparam int ST_TC_PROD  = 3;
    localparam int ST_TC_SUM   = 4;
    localparam int ST_OUT      = 5;
    localparam int PIPE_STAGES = 6;

    // Second Hamilton product r = t * conj(q): each output axis sums four
    // products t[PROD_T] * c[PROD_C], negated where PROD_NEG is set.
    localparam int NUM_PROD      = 12;
    localparam int PROD_PER_AXIS = 4;
    localparam int PROD_T [NUM_PROD] = '{0, 1, 2, 3, 0, 1, 2, 3, 0, 1, 2, 3};
    localparam int PROD_C [NUM_PROD] = '{3, 2, 1, 0, 2, 3, 0, 1, 1, 0, 3, 2};
    localparam logic [NUM_PROD-1:0] PROD_NEG = 12'b0010_0001_0100;

    // Stage enables and the output valid flag, shared by all datapath stages.
    typedef struct packed {
        logic [PIPE_STAGES-1:0] en;
        logic                   out_vld;
    } t_pipe_ctl;

endpackage

[hdl/qpr_point_if.sv]
// Request channel that carries one input point.
interface qpr_point_if #(
    parameter int W = qpr_pkg::COORD_BITS_DEF
) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] point_x;
    logic signed [W-1:0] point_y;
    logic signed [W-1:0] point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    output ready);
endinterface

[hdl/qpr_result_if.sv]
// Result channel that carries one rotated point.
interface qpr_result_if #(
    parameter int W = qpr_pkg::COORD_BITS_DEF
) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] out_x;
    logic signed [W-1:0] out_y;
    logic signed [W-1:0] out_z;

    modport source (output valid, output out_x, output out_y, output out_z,
                    input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z,
                    output ready);
endinterface

[hdl/qpr_cfg_regs.sv]
// Quaternion configuration registers with their write port.
module qpr_cfg_regs #(
    parameter int QW = qpr_pkg::QUAT_FRAC_BITS_DEF + 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_we,
    input  logic [qpr_pkg::CFG_IDX_BITS-1:0]    i_idx,
    input  logic [QW-1:0]                       i_data,
    output logic signed [QW-1:0]                o_q [qpr_pkg::NUM_REGS]
);
    import qpr_pkg::*;

    logic signed [QW-1:0] r_q [NUM_REGS];

    // Reset leaves the identity rotation: w just below one, vector part zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q[IX] <= '0;
            r_q[IY] <= '0;
            r_q[IZ] <= '0;
            r_q[IW] <= {1'b0, {(QW-1){1'b1}}};
        end else if (i_we) begin
            case (t_reg_idx'(i_idx))
                REG_ROT_X: r_q[IX] <= i_data;
                REG_ROT_Y: r_q[IY] <= i_data;
                REG_ROT_Z: r_q[IZ] <= i_data;
                REG_ROT_W: r_q[IW] <= i_data;
                default: begin
                end
            endcase
        end
    end

    assign o_q = r_q;

endmodule

[hdl/qpr_pipe_ctl.sv]
// Valid bits and stage enables of the rotator pipeline.
module qpr_pipe_ctl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_ready,
    output qpr_pkg::t_pipe_ctl o_ctl
);
    import qpr_pkg::*;

    logic [PIPE_STAGES-1:0] r_vld;
    logic [PIPE_STAGES-1:0] w_en;

    // A stage loads when it is empty or when the stage after it moves on,
    // so bubbles close up and a full pipe stalls as one.
    always_comb begin
        w_en[PIPE_STAGES-1] = !r_vld[PIPE_STAGES-1] || i_out_ready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    // Valid bits move together with the data they tag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < PIPE_STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_ctl.en      = w_en;
    assign o_ctl.out_vld = r_vld[PIPE_STAGES-1];

endmodule

[hdl/qpr_qp_mul.sv]
// First Hamilton product t = q * p: twelve products, then four sums.
module qpr_qp_mul #(
    parameter int CW = qpr_pkg::COORD_BITS_DEF,
    parameter int QW = qpr_pkg::QUAT_FRAC_BITS_DEF + 1,
    localparam int MW = QW + CW,
    localparam int TW = MW + 2
) (
    input  logic                        i_clk,
    input  qpr_pkg::t_pipe_ctl          i_ctl,
    input  logic signed [QW-1:0]        i_q [qpr_pkg::NUM_REGS],
    input  logic signed [CW-1:0]        i_px,
    input  logic signed [CW-1:0]        i_py,
    input  logic signed [CW-1:0]        i_pz,
    output logic signed [TW-1:0]        o_t [qpr_pkg::NUM_REGS]
);
    import qpr_pkg::*;

    logic signed [MW-1:0] r_yz, r_zy, r_wx;
    logic signed [MW-1:0] r_xz, r_zx, r_wy;
    logic signed [MW-1:0] r_xy, r_yx, r_wz;
    logic signed [MW-1:0] r_xx, r_yy, r_zz;
    logic signed [TW-1:0] r_t [NUM_REGS];

    // Stage one: every component product the point needs (p has w = 0).
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_QP_MUL]) begin
            r_yz <= MW'(i_q[IY]) * MW'(i_pz);
            r_zy <= MW'(i_q[IZ]) * MW'(i_py);
            r_wx <= MW'(i_q[IW]) * MW'(i_px);
            r_xz <= MW'(i_q[IX]) * MW'(i_pz);
            r_zx <= MW'(i_q[IZ]) * MW'(i_px);
            r_wy <= MW'(i_q[IW]) * MW'(i_py);
            r_xy <= MW'(i_q[IX]) * MW'(i_py);
            r_yx <= MW'(i_q[IY]) * MW'(i_px);
            r_wz <= MW'(i_q[IW]) * MW'(i_pz);
            r_xx <= MW'(i_q[IX]) * MW'(i_px);
            r_yy <= MW'(i_q[IY]) * MW'(i_py);
            r_zz <= MW'(i_q[IZ]) * MW'(i_pz);
        end
    end

    // Stage two: the four components of q * p, exact.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_QP_SUM]) begin
            r_t[IX] <= TW'(r_yz) - TW'(r_zy) + TW'(r_wx);
            r_t[IY] <= TW'(r_zx) - TW'(r_xz) + TW'(r_wy);
            r_t[IZ] <= TW'(r_xy) - TW'(r_yx) + TW'(r_wz);
            r_t[IW] <= -TW'(r_xx) - TW'(r_yy) - TW'(r_zz);
        end
    end

    assign o_t = r_t;

endmodule

[hdl/qpr_tc_mul.sv]
// Second Hamilton product r = t * conj(q), with each wide product split in two halves.
module qpr_tc_mul #(
    parameter int CW = qpr_pkg::COORD_BITS_DEF,
    parameter int QW = qpr_pkg::QUAT_FRAC_BITS_DEF + 1,
    localparam int TW = QW + CW + 2,
    localparam int RW = TW + QW + 3
) (
    input  logic                        i_clk,
    input  qpr_pkg::t_pipe_ctl          i_ctl,
    input  logic signed [QW-1:0]        i_q [qpr_pkg::NUM_REGS],
    input  logic signed [TW-1:0]        i_t [qpr_pkg::NUM_REGS],
    output logic signed [RW-1:0]        o_r [3]
);
    import qpr_pkg::*;

    // Conjugate is one bit wider so that negating the most negative value stays exact.
    localparam int CQ  = QW + 1;
    localparam int LO  = TW / 2;
    localparam int HI  = TW - LO;
    localparam int PLW = LO + 1 + CQ;
    localparam int PHW = HI + CQ;
    localparam int PW  = TW + CQ;

    logic signed [CQ-1:0]  w_c [NUM_REGS];
    logic signed [PLW-1:0] r_plo [NUM_PROD];
    logic signed [PHW-1:0] r_phi [NUM_PROD];
    logic signed [PW-1:0]  r_prod [NUM_PROD];
    logic signed [RW-1:0]  r_r [3];
    logic signed [RW-1:0]  n_r [3];

    assign w_c[IX] = -CQ'(i_q[IX]);
    assign w_c[IY] = -CQ'(i_q[IY]);
    assign w_c[IZ] = -CQ'(i_q[IZ]);
    assign w_c[IW] = CQ'(i_q[IW]);

    for (genvar k = 0; k < NUM_PROD; k++) begin : g_prod
        logic signed [LO:0]   w_lo;
        logic signed [HI-1:0] w_hi;

        // The low half is taken unsigned, the high half carries the sign.
        assign w_lo = $signed({1'b0, i_t[PROD_T[k]][LO-1:0]});
        assign w_hi = i_t[PROD_T[k]][TW-1:LO];

        // Stage three: partial products of each half.
        always_ff @(posedge i_clk) begin
            if (i_ctl.en[ST_TC_MUL]) begin
                r_plo[k] <= PLW'(w_lo) * PLW'(w_c[PROD_C[k]]);
                r_phi[k] <= PHW'(w_hi) * PHW'(w_c[PROD_C[k]]);
            end
        end

        // Stage four: the halves recombined into the full product.
        always_ff @(posedge i_clk) begin
            if (i_ctl.en[ST_TC_PROD]) begin
                r_prod[k] <= (PW'(r_phi[k]) <<< LO) + PW'(r_plo[k]);
            end
        end
    end

    // Stage five: signed sum of four products for each axis.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_r[i] = '0;
            for (int m = 0; m < PROD_PER_AXIS; m++) begin
                if (PROD_NEG[i*PROD_PER_AXIS + m]) begin
                    n_r[i] = n_r[i] - RW'(r_prod[i*PROD_PER_AXIS + m]);
                end else begin
                    n_r[i] = n_r[i] + RW'(r_prod[i*PROD_PER_AXIS + m]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_TC_SUM]) begin
            r_r <= n_r;
        end
    end

    assign o_r = r_r;

endmodule

[hdl/qpr_round_sat.sv]
// Output stage: scale down, round to nearest with ties up, saturate, register.
module qpr_round_sat #(
    parameter int CW = qpr_pkg::COORD_BITS_DEF,
    parameter int QW = qpr_pkg::QUAT_FRAC_BITS_DEF + 1,
    localparam int RW = 2 * QW + CW + 5
) (
    input  logic                        i_clk,
    input  qpr_pkg::t_pipe_ctl          i_ctl,
    input  logic signed [RW-1:0]        i_r [3],
    output logic signed [CW-1:0]        o_x,
    output logic signed [CW-1:0]        o_y,
    output logic signed [CW-1:0]        o_z
);
    import qpr_pkg::*;

    // The sum is taken as a 64-bit two's complement word before rounding.
    localparam int                 SHIFT  = 2 * (QW - 1);
    localparam logic signed [63:0] HALF   = 64'sd1 <<< (SHIFT - 1);
    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (CW - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

    logic signed [CW-1:0] n_out [3];
    logic signed [CW-1:0] r_out [3];

    always_comb begin
        logic signed [63:0] acc;
        logic signed [63:0] scaled;
        for (int i = 0; i < 3; i++) begin
            acc    = $signed(64'(i_r[i])) + HALF;
            scaled = acc >>> SHIFT;
            if (scaled > SAT_HI) begin
                n_out[i] = CW'(SAT_HI);
            end else if (scaled < SAT_LO) begin
                n_out[i] = CW'(SAT_LO);
            end else begin
                n_out[i] = CW'(scaled);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_OUT]) begin
            r_out <= n_out;
        end
    end

    assign o_x = r_out[0];
    assign o_y = r_out[1];
    assign o_z = r_out[2];

endmodule

[hdl/quaternion_point_rotator.sv]
// Top level of the quaternion point rotator: register file, pipeline control and datapath.
// The block rotates each point p by the quaternion q in its registers as q * p * conj(q),
// returning the vector part rounded to nearest (ties up) and saturated to the coordinate
// range. It takes one point per cycle while the output does not stall; the six register
// stages are set by the two chained quaternion products, the second of which is split
// into half-width partial products over two stages. A stall at the output holds the pipe
// in place; empty stages close up, so the input stays ready while any stage is free.
// Write the four registers only while no point is in flight; q is not normalized, so a
// non-unit quaternion scales the result by its squared length.
module quaternion_point_rotator #(
    parameter int COORD_BITS     = qpr_pkg::COORD_BITS_DEF,
    parameter int QUAT_FRAC_BITS = qpr_pkg::QUAT_FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [qpr_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [QUAT_FRAC_BITS:0]          i_cfg_data,
    qpr_point_if.sink                        i_point,
    qpr_result_if.source                     o_result
);
    import qpr_pkg::*;

    localparam int QW = QUAT_FRAC_BITS + 1;
    localparam int TW = QW + COORD_BITS + 2;
    localparam int RW = TW + QW + 3;

    logic signed [QW-1:0] w_q [NUM_REGS];
    logic signed [TW-1:0] w_t [NUM_REGS];
    logic signed [RW-1:0] w_r [3];
    t_pipe_ctl            w_ctl;

    qpr_cfg_regs #(
        .QW (QW)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_q     (w_q)
    );

    qpr_pipe_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_point.valid),
        .i_out_ready (o_result.ready),
        .o_ctl       (w_ctl)
    );

    qpr_qp_mul #(
        .CW (COORD_BITS),
        .QW (QW)
    ) u_qp (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .i_q   (w_q),
        .i_px  (i_point.point_x),
        .i_py  (i_point.point_y),
        .i_pz  (i_point.point_z),
        .o_t   (w_t)
    );

    qpr_tc_mul #(
        .CW (COORD_BITS),
        .QW (QW)
    ) u_tc (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .i_q   (w_q),
        .i_t   (w_t),
        .o_r   (w_r)
    );

    qpr_round_sat #(
        .CW (COORD_BITS),
        .QW (QW)
    ) u_out (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .i_r   (w_r),
        .o_x   (o_result.out_x),
        .o_y   (o_result.out_y),
        .o_z   (o_result.out_z)
    );

    // Handshake: the first stage takes a request whenever it may load.
    assign i_point.ready  = w_ctl.en[ST_QP_MUL];
    assign o_result.valid = w_ctl.out_vld;

endmodule

[hdl/qpr_checker.sv]
// Port-level assertions of the quaternion point rotator and their bind.
module qpr_checker #(
    parameter int CW = qpr_pkg::COORD_BITS_DEF
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input logic [CW-1:0] i_out_x,
    input logic [CW-1:0] i_out_y,
    input logic [CW-1:0] i_out_z
);

    // Reset empties the pipe: no result shows in the cycle after it.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // With the output free or taken, every stage can move, so the input is open.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("input stalled while the output side is free");

    // A stalled result stays and keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_x) && $stable(i_out_y) && $stable(i_out_z)))
        else $error("stalled result changed or dropped");

    // An offered request is held off only while a result waits at the output.
    a_in_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !i_in_ready) |-> (i_out_valid && !i_out_ready))
        else $error("input stalled without an output stall");

endmodule

bind quaternion_point_rotator qpr_checker #(
    .CW (COORD_BITS)
) u_qpr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_point.valid),
    .i_in_ready  (i_point.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_x     (o_result.out_x),
    .i_out_y     (o_result.out_y),
    .i_out_z     (o_result.out_z)
);

[tb/tb_quaternion_point_rotator.sv]
// Self-checking testbench of the quaternion point rotator: directed and random points, random idling.
`timescale 1ns / 100ps

module tb_quaternion_point_rotator;
    import qpr_pkg::*;

    typedef logic signed [COORD_BITS_DEF-1:0]   t_coord;
    typedef logic signed [QUAT_FRAC_BITS_DEF:0] t_quat_comp;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_point;

    // Keeps a copy of the rotation registers and the rotated points still owed by the block.
    class rotation_scoreboard;
        t_quat_comp  quat [NUM_REGS];
        t_point      pending_rotations [$];
        int unsigned points_noted;
        int unsigned results_checked;
        int unsigned errors;

        function new();
            quat[IX] = '0;
            quat[IY] = '0;
            quat[IZ] = '0;
            quat[IW] = t_quat_comp'((1 << QUAT_FRAC_BITS_DEF) - 1);
            points_noted    = 0;
            results_checked = 0;
            errors          = 0;
        endfunction

        function void set_reg(t_reg_idx idx, t_quat_comp val);
            quat[idx] = val;
        endfunction

        function int pending();
            return pending_rotations.size();
        endfunction

        // Hamilton product a * b on (x, y, z, w); all terms are exact in 64 bits.
        function void hamilton(input longint a [4], input longint b [4],
                               output longint r [4]);
            r[IX] =  a[IX] * b[IW] + a[IY] * b[IZ] - a[IZ] * b[IY] + a[IW] * b[IX];
            r[IY] = -a[IX] * b[IZ] + a[IY] * b[IW] + a[IZ] * b[IX] + a[IW] * b[IY];
            r[IZ] =  a[IX] * b[IY] - a[IY] * b[IX] + a[IZ] * b[IW] + a[IW] * b[IZ];
            r[IW] = -a[IX] * b[IX] - a[IY] * b[IY] - a[IZ] * b[IZ] + a[IW] * b[IW];
        endfunction

        // Drops both quaternion scales, rounding half up, then clamps to the coordinate range.
        function t_coord round_sat(longint acc);
            longint v;
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (COORD_BITS_DEF - 1)) - 1;
            lo = -hi - 1;
            v  = (acc + (longint'(1) <<< (2 * QUAT_FRAC_BITS_DEF - 1)))
                 >>> (2 * QUAT_FRAC_BITS_DEF);
            if (v > hi)
                v = hi;
            if (v < lo)
                v = lo;
            return t_coord'(v);
        endfunction

        // Rotated point q * p * conj(q); the conjugate keeps a negated minimum component exact.
        function t_point rotate_point(t_point p_in);
            longint q [4];
            longint c [4];
            longint p [4];
            longint t [4];
            longint r [4];
            t_point res;
            foreach (q[i])
                q[i] = longint'(quat[i]);
            p[IX] = longint'(p_in.x);
            p[IY] = longint'(p_in.y);
            p[IZ] = longint'(p_in.z);
            p[IW] = 0;
            c[IX] = -q[IX];
            c[IY] = -q[IY];
            c[IZ] = -q[IZ];
            c[IW] = q[IW];
            hamilton(q, p, t);
            hamilton(t, c, r);
            res.x = round_sat(r[IX]);
            res.y = round_sat(r[IY]);
            res.z = round_sat(r[IZ]);
            return res;
        endfunction

        function void note_point(t_point p);
            pending_rotations.push_back(rotate_point(p));
            points_noted++;
        endfunction

        function void compare_field(string name, t_coord want, t_coord got);
            if (got !== want) begin
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_point got);
            t_point want;
            if (pending_rotations.size() == 0) begin
                $display("%0t: rotated point (%0d, %0d, %0d) arrived with no request pending",
                         $time, got.x, got.y, got.z);
                errors++;
                return;
            end
            want = pending_rotations.pop_front();
            results_checked++;
            compare_field("out_x", want.x, got.x);
            compare_field("out_y", want.y, got.y);
            compare_field("out_z", want.z, got.z);
        endfunction
    endclass

    localparam int CW            = COORD_BITS_DEF;
    localparam int QFB           = QUAT_FRAC_BITS_DEF;
    localparam int HOLD_CYCLES   = 60;
    localparam int DRAIN_CYCLES  = 12;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_POINTS  = 130;

    localparam t_coord     COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam t_coord     COORD_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam t_quat_comp QUAT_MAX  = {1'b0, {QFB{1'b1}}};
    localparam t_quat_comp QUAT_MIN  = {1'b1, {QFB{1'b0}}};

    typedef enum int {PT_FULL, PT_SMALL, PT_EDGE} t_pt_mode;
    typedef enum int {QT_FULL, QT_HALF, QT_EDGE} t_qt_mode;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_cfg_we;
    t_reg_idx       i_cfg_idx;
    logic [QFB:0]   i_cfg_data;

    qpr_point_if  #(.W(CW)) pt_if ();
    qpr_result_if #(.W(CW)) res_if ();

    rotation_scoreboard sb;

    bit          quiet_sender   = 1'b0;
    bit          quiet_receiver = 1'b0;
    bit          hold_results   = 1'b0;
    int unsigned cycle_count    = 0;
    int unsigned settings_used  = 1;

    quaternion_point_rotator #(
        .COORD_BITS     (CW),
        .QUAT_FRAC_BITS (QFB)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_point    (pt_if),
        .o_result   (res_if)
    );

    // Free-running clock with an 8 ns period.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Cycle counter and the timeout that it guards.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic t_coord rand_coord(t_pt_mode mode);
        case (mode)
            PT_FULL: begin
                return t_coord'($urandom);
            end
            PT_SMALL: begin
                return t_coord'(int'($urandom_range(0, 4000)) - 2000);
            end
            default: begin
                case ($urandom_range(0, 4))
                    0: return COORD_MAX;
                    1: return COORD_MIN;
                    2: return t_coord'(0);
                    3: return t_coord'(1);
                    default: return t_coord'(-1);
                endcase
            end
        endcase
    endfunction

    function automatic t_quat_comp rand_quat(t_qt_mode mode);
        case (mode)
            QT_FULL: begin
                return t_quat_comp'($urandom);
            end
            QT_HALF: begin
                return t_quat_comp'(int'($urandom_range(0, 32768)) - 16384);
            end
            default: begin
                case ($urandom_range(0, 4))
                    0: return QUAT_MAX;
                    1: return QUAT_MIN;
                    2: return t_quat_comp'(0);
                    3: return t_quat_comp'(1);
                    default: return t_quat_comp'(-1);
                endcase
            end
        endcase
    endfunction

    // Offers one point after a random gap and waits until the block takes it.
    task automatic send_point(t_coord x, t_coord y, t_coord z);
        int     gap;
        t_point p;
        gap = quiet_sender ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            pt_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pt_if.valid   <= 1'b1;
        pt_if.point_x <= x;
        pt_if.point_y <= y;
        pt_if.point_z <= z;
        do @(posedge i_clk); while (!pt_if.ready);
        p.x = x;
        p.y = y;
        p.z = z;
        sb.note_point(p);
    endtask

    // Stops offering points and waits until every rotated point has come back.
    task automatic drain_points();
        pt_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic write_reg(t_reg_idx idx, t_quat_comp val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    // Loads a new quaternion once the pipe is empty.
    task automatic load_rotation(t_quat_comp qx, t_quat_comp qy,
                                 t_quat_comp qz, t_quat_comp qw);
        drain_points();
        write_reg(REG_ROT_X, qx);
        write_reg(REG_ROT_Y, qy);
        write_reg(REG_ROT_Z, qz);
        write_reg(REG_ROT_W, qw);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Result side: random stalls, one long hold on request, checks every accepted result.
    initial begin : result_sink
        int     stall;
        t_point got;
        res_if.ready = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = quiet_receiver ? 0 : $urandom_range(0, 3);
            if (hold_results) begin
                hold_results = 1'b0;
                stall        = HOLD_CYCLES;
            end
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
            got.x = res_if.out_x;
            got.y = res_if.out_y;
            got.z = res_if.out_z;
            sb.check_result(got);
        end
    end

    // Main stimulus: reset, directed cases, random phases, final drain.
    initial begin : stimulus
        t_qt_mode qmode;
        sb            = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_ROT_X;
        i_cfg_data    = '0;
        pt_if.valid   = 1'b0;
        pt_if.point_x = '0;
        pt_if.point_y = '0;
        pt_if.point_z = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset quaternion, just short of identity.
        send_point(COORD_MAX, COORD_MAX, COORD_MAX);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN);
        send_point(t_coord'(0), t_coord'(0), t_coord'(0));
        send_point(t_coord'(1), t_coord'(-1), t_coord'(1));
        send_point(COORD_MIN, COORD_MAX, t_coord'(0));

        // Quarter turn about z.
        load_rotation(t_quat_comp'(0), t_quat_comp'(0),
                      t_quat_comp'(23170), t_quat_comp'(23170));
        send_point(t_coord'(1000), t_coord'(0), t_coord'(0));
        send_point(t_coord'(0), t_coord'(1000), t_coord'(0));
        send_point(COORD_MAX, t_coord'(0), t_coord'(0));
        send_point(COORD_MIN, COORD_MIN, COORD_MAX);

        // Half turn about x with the most negative component, exact at unit length.
        load_rotation(QUAT_MIN, t_quat_comp'(0), t_quat_comp'(0), t_quat_comp'(0));
        send_point(COORD_MAX, COORD_MAX, COORD_MAX);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN);
        send_point(t_coord'(12345), t_coord'(-6789), t_coord'(42));

        // Non-unit quaternions scale the result and drive large points into saturation.
        load_rotation(QUAT_MIN, QUAT_MIN, QUAT_MIN, QUAT_MIN);
        send_point(COORD_MAX, COORD_MIN, t_coord'(0));
        send_point(t_coord'(100000), t_coord'(-3), t_coord'(7));
        send_point(t_coord'(1), t_coord'(1), t_coord'(1));
        load_rotation(QUAT_MAX, QUAT_MAX, QUAT_MAX, QUAT_MAX);
        send_point(COORD_MIN, t_coord'(0), COORD_MAX);
        send_point(t_coord'(-1), t_coord'(-1), t_coord'(-1));

        // A zero quaternion collapses every point.
        load_rotation(t_quat_comp'(0), t_quat_comp'(0), t_quat_comp'(0), t_quat_comp'(0));
        send_point(COORD_MAX, COORD_MAX, COORD_MAX);

        // Quarter scale puts results on exact halves, which round toward plus infinity.
        load_rotation(t_quat_comp'(0), t_quat_comp'(0), t_quat_comp'(0), t_quat_comp'(16384));
        send_point(t_coord'(2), t_coord'(-2), t_coord'(6));
        send_point(t_coord'(-6), t_coord'(3), t_coord'(-3));

        // Random phases, each with its own quaternion and idling pattern.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            qmode = t_qt_mode'($urandom_range(0, 2));
            load_rotation(rand_quat(qmode), rand_quat(qmode), rand_quat(qmode), rand_quat(qmode));
            quiet_sender   = (ph == 1 || ph == 2) ? 1'b1 : ($urandom_range(0, 3) == 0);
            quiet_receiver = (ph == 1) ? 1'b1 : ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_POINTS; n++) begin
                // The long output hold lets the pipe fill and push back on the input.
                if (ph == 2 && n == 20)
                    hold_results = 1'b1;
                // One pause mid-phase until every owed result has come back.
                if (ph == 4 && n == 60)
                    drain_points();
                send_point(rand_coord(t_pt_mode'($urandom_range(0, 2))),
                           rand_coord(t_pt_mode'($urandom_range(0, 2))),
                           rand_coord(t_pt_mode'($urandom_range(0, 2))));
            end
        end

        drain_points();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Rotated %0d points under %0d quaternion settings, %0d results checked.",
                 sb.points_noted, settings_used, sb.results_checked);
        $display("Covered extreme, non-unit and tie-rounding cases, idling and a full-pipe stall.");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[quaternion_point_rotator.f]
hdl/qpr_pkg.sv
hdl/qpr_point_if.sv
hdl/qpr_result_if.sv
hdl/qpr_cfg_regs.sv
hdl/qpr_pipe_ctl.sv
hdl/qpr_qp_mul.sv
hdl/qpr_tc_mul.sv
hdl/qpr_round_sat.sv
hdl/quaternion_point_rotator.sv
hdl/qpr_checker.sv
tb/tb_quaternion_point_rotator.sv
